// ===== design/r2y_pkg.sv =====
// Shared constants, types and color-weight functions of the RGB to YUV 4:2:0 converter.
package r2y_pkg;

  // Configuration port
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam int FRAME_WIDTH_RESET  = 640;
  localparam int FRAME_HEIGHT_RESET = 480;

  // Parameter defaults
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam int PIX_W = 8;
  localparam int SUM_W = 9;   // pair sum of two per-pixel chroma values

  // BT.601 limited-range weights (magnitudes, signs applied in the functions)
  localparam int unsigned K_Y_R  = 66;
  localparam int unsigned K_Y_G  = 129;
  localparam int unsigned K_Y_B  = 25;
  localparam int unsigned K_CB_R = 38;
  localparam int unsigned K_CB_G = 74;
  localparam int unsigned K_CB_B = 112;
  localparam int unsigned K_CR_R = 112;
  localparam int unsigned K_CR_G = 94;
  localparam int unsigned K_CR_B = 18;
  localparam int unsigned ROUND_HALF = 128;
  localparam int unsigned LUMA_OFS   = 16;
  localparam int unsigned CHROMA_OFS = 128;
  // Rounding plus the chroma offset moved ahead of the shift keeps the sum positive
  localparam int unsigned CHROMA_BIAS = ROUND_HALF + (CHROMA_OFS << 8);

  // Control handed from the pixel pipeline to the chroma averager
  typedef struct packed {
    logic fire;      // the pixel in the compute stage moves on this cycle
    logic col_odd;
    logic row_odd;
  } chroma_ctl_t;

  function automatic logic [PIX_W-1:0] calc_luma(input logic [PIX_W-1:0] r,
                                                  input logic [PIX_W-1:0] g,
                                                  input logic [PIX_W-1:0] b);
    logic [15:0] s;
    s = 16'(K_Y_R * r) + 16'(K_Y_G * g) + 16'(K_Y_B * b) + 16'(ROUND_HALF);
    return s[15:8] + PIX_W'(LUMA_OFS);
  endfunction

  function automatic logic [PIX_W-1:0] calc_cb(input logic [PIX_W-1:0] r,
                                                input logic [PIX_W-1:0] g,
                                                input logic [PIX_W-1:0] b);
    logic [16:0] s;
    s = 17'(K_CB_B * b) + 17'(CHROMA_BIAS) - 17'(K_CB_R * r) - 17'(K_CB_G * g);
    return s[15:8];
  endfunction

  function automatic logic [PIX_W-1:0] calc_cr(input logic [PIX_W-1:0] r,
                                                input logic [PIX_W-1:0] g,
                                                input logic [PIX_W-1:0] b);
    logic [16:0] s;
    s = 17'(K_CR_R * r) + 17'(CHROMA_BIAS) - 17'(K_CR_G * g) - 17'(K_CR_B * b);
    return s[15:8];
  endfunction

endpackage

// ===== design/r2y_chroma_avg.sv =====
// Chroma 2x2 averager: pending even-column values and the line store of even-row pair sums.
module r2y_chroma_avg #(
  parameter int LINE_PAIRS = r2y_pkg::MAX_WIDTH_DEF / 2,
  parameter int IDX_W      = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [IDX_W-1:0]         rd_idx,
  input  r2y_pkg::chroma_ctl_t     ctl,
  input  logic [IDX_W-1:0]         wr_idx,
  input  logic [r2y_pkg::PIX_W-1:0] cb,
  input  logic [r2y_pkg::PIX_W-1:0] cr,
  output logic                     chroma_valid,
  output logic [r2y_pkg::PIX_W-1:0] blue_diff,
  output logic [r2y_pkg::PIX_W-1:0] red_diff
);
  import r2y_pkg::*;

  logic [PIX_W-1:0] pending_cb_r;
  logic [PIX_W-1:0] pending_cr_r;

  // One entry holds the Cb and Cr pair sums of one column pair
  logic [2*SUM_W-1:0] line_mem [LINE_PAIRS];
  logic [2*SUM_W-1:0] rd_data_r;

  logic [SUM_W-1:0] pair_cb;
  logic [SUM_W-1:0] pair_cr;
  logic [SUM_W:0]   quad_cb;
  logic [SUM_W:0]   quad_cr;
  logic             wr_en;

  assign pair_cb = SUM_W'(pending_cb_r) + SUM_W'(cb);
  assign pair_cr = SUM_W'(pending_cr_r) + SUM_W'(cr);
  assign wr_en   = ctl.fire & ctl.col_odd & ~ctl.row_odd;

  // Odd row: add the stored even-row pair to this row's pair, divide by four
  assign quad_cb = (SUM_W+1)'(rd_data_r[2*SUM_W-1:SUM_W]) + (SUM_W+1)'(pair_cb);
  assign quad_cr = (SUM_W+1)'(rd_data_r[SUM_W-1:0]) + (SUM_W+1)'(pair_cr);

  assign chroma_valid = ctl.col_odd & ctl.row_odd;
  assign blue_diff    = chroma_valid ? quad_cb[SUM_W:2] : '0;
  assign red_diff     = chroma_valid ? quad_cr[SUM_W:2] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_cb_r <= '0;
      pending_cr_r <= '0;
    end else if (ctl.fire && !ctl.col_odd) begin
      pending_cb_r <= cb;
      pending_cr_r <= cr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_idx] <= {pair_cb, pair_cr};
    end
  end

  // Hold the read data while the pixel waits in the compute stage
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= line_mem[rd_idx];
    end
  end

endmodule

// ===== design/rgb_to_yuv420_converter_core.sv =====
// RGB to YUV 4:2:0 converter top level: position counters, pixel pipeline, output register.
// Path: an accepted input beat passes through stage A and stage B before its result beat is
// loaded into the output register, where the result handshake then takes place.
// Throughput: one pixel per cycle while out_stall is low; set by the line store, which is read
// one stage ahead and written back in the compute stage, one read and one write port per cycle.
// Reset: position counters cleared, frame size 640 x 480, pipeline empty, pending
// chroma cleared; the line store is not cleared, each entry is written on an even row
// before the odd row reads it.
module rgb_to_yuv420_converter_core #(
  parameter int MAX_WIDTH  = r2y_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = r2y_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [r2y_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [r2y_pkg::CFG_W-1:0]     cfg_data,
  // pixel input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [r2y_pkg::PIX_W-1:0]     in_red,
  input  logic [r2y_pkg::PIX_W-1:0]     in_green,
  input  logic [r2y_pkg::PIX_W-1:0]     in_blue,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [r2y_pkg::PIX_W-1:0]     out_luma,
  output logic                          out_chroma_valid,
  output logic [r2y_pkg::PIX_W-1:0]     out_blue_diff,
  output logic [r2y_pkg::PIX_W-1:0]     out_red_diff,
  output logic                          out_end_of_frame
);
  import r2y_pkg::*;

  localparam int CW         = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW         = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int LINE_PAIRS = MAX_WIDTH / 2;
  localparam int IDX_W      = (LINE_PAIRS > 1) ? $clog2(LINE_PAIRS) : 1;
  localparam int DIM_W      = (CW > RW) ? CW + 1 : RW + 1;
  localparam int SZ_W       = (DIM_W > CFG_W) ? DIM_W : CFG_W;

  // Drop the low bit, then saturate to 2..max
  function automatic logic [SZ_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [SZ_W-1:0]  maxv);
    logic [SZ_W-1:0] e;
    e = SZ_W'({v[CFG_W-1:1], 1'b0});
    if (e < SZ_W'(2)) e = SZ_W'(2);
    if (e > maxv) e = maxv;
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Frame size registers, stored already clamped
  // ---------------------------------------------------------------------------
  logic [SZ_W-1:0] width_r;
  logic [SZ_W-1:0] height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= clamp_size(CFG_W'(FRAME_WIDTH_RESET), SZ_W'(MAX_WIDTH));
      height_r <= clamp_size(CFG_W'(FRAME_HEIGHT_RESET), SZ_W'(MAX_HEIGHT));
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  width_r  <= clamp_size(cfg_data, SZ_W'(MAX_WIDTH));
        REG_FRAME_HEIGHT: height_r <= clamp_size(cfg_data, SZ_W'(MAX_HEIGHT));
        default: ;  // writes beyond the register list are ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage enables: each stage advances when it is empty or the next one moves,
  // so while stage A or B is empty the pipeline keeps accepting as a finished beat waits at the output
  // ---------------------------------------------------------------------------
  logic a_valid_r;
  logic b_valid_r;
  logic out_valid_r;
  logic en_a;
  logic en_b;
  logic en_c;
  logic in_fire;

  assign en_c     = ~out_valid_r | ~out_stall;
  assign en_b     = ~b_valid_r | en_c;
  assign en_a     = ~a_valid_r | en_b;
  assign in_stall = ~en_a;
  assign in_fire  = in_valid & en_a;

  // ---------------------------------------------------------------------------
  // Raster position of the next pixel
  // ---------------------------------------------------------------------------
  logic [CW-1:0]    col_r;
  logic [CW-1:0]    col_nxt;
  logic [RW-1:0]    row_r;
  logic [RW-1:0]    row_nxt;
  logic [SZ_W-1:0]  col_inc;
  logic [SZ_W-1:0]  row_inc;
  logic             line_wrap;
  logic             frame_end;
  logic [CW-1:0]    pair_pos;
  logic [IDX_W-1:0] pos_idx;

  assign col_inc   = SZ_W'(col_r) + SZ_W'(1);
  assign row_inc   = SZ_W'(row_r) + SZ_W'(1);
  assign line_wrap = (col_inc >= width_r);
  assign frame_end = line_wrap & (row_inc >= height_r);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (line_wrap) begin
      col_nxt = '0;
      row_nxt = frame_end ? '0 : RW'(row_inc);
    end else begin
      col_nxt = CW'(col_inc);
    end
  end

  // Column pair index into the line store, wrapped at the store depth
  assign pair_pos = col_r >> 1;
  assign pos_idx  = (pair_pos >= CW'(LINE_PAIRS)) ? IDX_W'(pair_pos - CW'(LINE_PAIRS))
                                                  : IDX_W'(pair_pos);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: captured pixel and its position; the line store read goes out
  // when the pixel advances to stage B
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] a_red_r;
  logic [PIX_W-1:0] a_green_r;
  logic [PIX_W-1:0] a_blue_r;
  logic [IDX_W-1:0] a_idx_r;
  logic             a_col_odd_r;
  logic             a_row_odd_r;
  logic             a_eof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en_a) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_red_r     <= in_red;
      a_green_r   <= in_green;
      a_blue_r    <= in_blue;
      a_idx_r     <= pos_idx;
      a_col_odd_r <= col_r[0];
      a_row_odd_r <= row_r[0];
      a_eof_r     <= frame_end;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: luma and per-pixel chroma; the averager updates its pending
  // values and the line store as the pixel leaves this stage
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] b_luma_r;
  logic [PIX_W-1:0] b_cb_r;
  logic [PIX_W-1:0] b_cr_r;
  logic [IDX_W-1:0] b_idx_r;
  logic             b_col_odd_r;
  logic             b_row_odd_r;
  logic             b_eof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en_b) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && a_valid_r) begin
      b_luma_r    <= calc_luma(a_red_r, a_green_r, a_blue_r);
      b_cb_r      <= calc_cb(a_red_r, a_green_r, a_blue_r);
      b_cr_r      <= calc_cr(a_red_r, a_green_r, a_blue_r);
      b_idx_r     <= a_idx_r;
      b_col_odd_r <= a_col_odd_r;
      b_row_odd_r <= a_row_odd_r;
      b_eof_r     <= a_eof_r;
    end
  end

  chroma_ctl_t      avg_ctl;
  logic             avg_valid;
  logic [PIX_W-1:0] avg_cb;
  logic [PIX_W-1:0] avg_cr;

  assign avg_ctl.fire    = b_valid_r & en_c;
  assign avg_ctl.col_odd = b_col_odd_r;
  assign avg_ctl.row_odd = b_row_odd_r;

  r2y_chroma_avg #(
    .LINE_PAIRS (LINE_PAIRS),
    .IDX_W      (IDX_W)
  ) u_chroma_avg (
    .clk          (clk),
    .rst_n        (rst_n),
    .rd_en        (en_b),
    .rd_idx       (a_idx_r),
    .ctl          (avg_ctl),
    .wr_idx       (b_idx_r),
    .cb           (b_cb_r),
    .cr           (b_cr_r),
    .chroma_valid (avg_valid),
    .blue_diff    (avg_cb),
    .red_diff     (avg_cr)
  );

  // ---------------------------------------------------------------------------
  // Output register: holds the result beat while the consumer stalls
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] out_luma_r;
  logic             out_chroma_valid_r;
  logic [PIX_W-1:0] out_blue_diff_r;
  logic [PIX_W-1:0] out_red_diff_r;
  logic             out_end_of_frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_c) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c && b_valid_r) begin
      out_luma_r         <= b_luma_r;
      out_chroma_valid_r <= avg_valid;
      out_blue_diff_r    <= avg_cb;
      out_red_diff_r     <= avg_cr;
      out_end_of_frame_r <= b_eof_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_luma         = out_luma_r;
  assign out_chroma_valid = out_chroma_valid_r;
  assign out_blue_diff    = out_blue_diff_r;
  assign out_red_diff     = out_red_diff_r;
  assign out_end_of_frame = out_end_of_frame_r;

endmodule
